### hw/rtl/tols_pkg.sv
`default_nettype none

package tols_pkg;

  // sizes
  localparam int MAX_NODES = 128;
  localparam int MAX_TOUR  = 64;
  localparam int DIST_BITS = 16;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int TIDX_W  = $clog2(MAX_TOUR);
  localparam int TCNT_W  = $clog2(MAX_TOUR + 1);
  localparam int JW      = (NCNT_W > TCNT_W) ? NCNT_W : TCNT_W;
  localparam int TNODE_W = 7;
  localparam int DW      = DIST_BITS + 3;
  localparam int ACC_W0  = DIST_BITS + $clog2(MAX_TOUR) + 2;
  localparam int ACC_W   = (ACC_W0 > 24) ? ACC_W0 : 24;
  localparam int COST_W  = 23;
  localparam logic [COST_W-1:0] COST_SAT = 23'h7FFFFF;

  // configuration port
  localparam int CFG_DW = 8;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_NODE_COUNT   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TOUR_LENGTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_INTRA_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    FN_DIST = 2'd0,
    FN_COST = 2'd1,
    FN_TOUR = 2'd2,
    FN_RUN  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TWO  = 2'd1,
    KIND_SWAP = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  row_node;
    logic [6:0]  col_node;
    logic [5:0]  tour_pos;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [6:0]        tour_node;
    logic [5:0]        out_pos;
    logic [COST_W-1:0] total_cost;
    logic              last;
  } out_word_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_W_D0, ST_W_D1, ST_W_C, ST_W_T,
    ST_MAP_CLR, ST_MAP_RD, ST_MAP_SET, ST_PASS,
    ST_O_I, ST_O_I2, ST_O_I3,
    ST_O_J0, ST_O_J1, ST_O_J2, ST_O_J3, ST_O_J4, ST_O_J5, ST_O_J6,
    ST_S_I, ST_S_I1, ST_S_I2, ST_S_I3, ST_S_I4, ST_S_I5, ST_S_I6,
    ST_S_J0, ST_S_J1, ST_S_J2, ST_S_J3,
    ST_AP, ST_V_RL, ST_V_RH, ST_V_WL, ST_V_WH, ST_SW_RD, ST_SW_WR,
    ST_T_I, ST_T_RD, ST_T_RD1, ST_T_RD2, ST_T_D, ST_T_A,
    ST_E_RD, ST_E_LD, ST_E_WAIT
  } state_e;

  typedef enum logic [5:0] {
    OP_NONE, OP_IDLE, OP_W_D0, OP_W_D1, OP_W_C, OP_W_T,
    OP_MAP_CLR, OP_MAP_RD, OP_MAP_SET, OP_PASS,
    OP_O_I, OP_O_I2, OP_O_I3,
    OP_O_J0, OP_O_J1, OP_O_J2, OP_O_J3, OP_O_J4, OP_O_J5, OP_O_J6,
    OP_S_I, OP_S_I1, OP_S_I2, OP_S_I3, OP_S_I4, OP_S_I5, OP_S_I6,
    OP_S_J0, OP_S_J1, OP_S_J2, OP_S_J3,
    OP_AP, OP_V_RL, OP_V_RH, OP_V_WL, OP_V_WH, OP_SW_RD, OP_SW_WR,
    OP_T_I, OP_T_RD, OP_T_RD1, OP_T_RD2, OP_T_D, OP_T_A,
    OP_E_RD, OP_E_LD, OP_E_ADV
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  intra;
    logic  i_end;
    logic  i_two_end;
    logic  j_last_t;
    logic  j_end_n;
    logic  j_in_map;
    logic  lo_lt_hi;
    logic  e_last;
    kind_e kind;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/tour_two_opt_local_search_core.sv
`default_nettype none

// steepest-descent 2-opt / node-swap local search over a selected-node tour
// input channel (in_valid_i / in_stall_o / in_word_i): one word per item,
//   func selects load distance, load node cost, load tour position or run
// output channel (out_valid_o / out_stall_i / out_word_o): a run returns one
//   word per tour position, last set on the final one; loads return nothing
// configuration: cfg_we_i writes node_count, tour_length or intra_enable;
//   write only while the block is idle (the block does not enforce this)
// a distance load writes the symmetric pair through the single write port
//   in W_D0 then W_D1; cost and tour loads write in W_C or W_T
// a run is data dependent: it rebuilds the membership map, then each pass
//   runs the 2-opt scan when enabled and the swap scan over node_count;
//   the best move is applied (an exchange swaps position pairs, a node swap
//   rewrites one position) until no move improves; the cost is then summed
//   and each output word waits while the receiver stalls
// in_stall_o is high from acceptance until a load completes or the last output word is taken
// a stalled output holds its word; the search does not restart
// reset returns registers to 128 / 64 / 1 and clears the membership map;
//   distance, cost and tour memories are not cleared

module tour_two_opt_local_search_core
  import tols_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_word_t          in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t st;

  tols_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  tols_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

`default_nettype wire

### hw/rtl/tols_ram.sv
`default_nettype none

module tols_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/tols_ctrl.sv
`default_nettype none

module tols_ctrl
  import tols_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (st_i.func)
            FN_DIST: state_d = ST_W_D0;
            FN_COST: state_d = ST_W_C;
            FN_TOUR: state_d = ST_W_T;
            default: state_d = ST_MAP_CLR;
          endcase
        end
      end
      ST_W_D0:    state_d = ST_W_D1;
      ST_W_D1:    state_d = ST_IDLE;
      ST_W_C:     state_d = ST_IDLE;
      ST_W_T:     state_d = ST_IDLE;
      ST_MAP_CLR: state_d = ST_MAP_RD;
      ST_MAP_RD:  state_d = st_i.i_end ? ST_PASS : ST_MAP_SET;
      ST_MAP_SET: state_d = ST_MAP_RD;
      ST_PASS:    state_d = st_i.intra ? ST_O_I : ST_S_I;
      ST_O_I:     state_d = st_i.i_two_end ? ST_S_I : ST_O_I2;
      ST_O_I2:    state_d = ST_O_I3;
      ST_O_I3:    state_d = ST_O_J0;
      ST_O_J0:    state_d = ST_O_J1;
      ST_O_J1:    state_d = ST_O_J2;
      ST_O_J2:    state_d = ST_O_J3;
      ST_O_J3:    state_d = ST_O_J4;
      ST_O_J4:    state_d = ST_O_J5;
      ST_O_J5:    state_d = ST_O_J6;
      ST_O_J6:    state_d = st_i.j_last_t ? ST_O_I : ST_O_J0;
      ST_S_I:     state_d = st_i.i_end ? ST_AP : ST_S_I1;
      ST_S_I1:    state_d = ST_S_I2;
      ST_S_I2:    state_d = ST_S_I3;
      ST_S_I3:    state_d = ST_S_I4;
      ST_S_I4:    state_d = ST_S_I5;
      ST_S_I5:    state_d = ST_S_I6;
      ST_S_I6:    state_d = ST_S_J0;
      ST_S_J0: begin
        if (st_i.j_end_n) begin
          state_d = ST_S_I;
        end else if (st_i.j_in_map) begin
          state_d = ST_S_J0;
        end else begin
          state_d = ST_S_J1;
        end
      end
      ST_S_J1:    state_d = ST_S_J2;
      ST_S_J2:    state_d = ST_S_J3;
      ST_S_J3:    state_d = ST_S_J0;
      ST_AP: begin
        case (st_i.kind)
          KIND_TWO:  state_d = ST_V_RL;
          KIND_SWAP: state_d = ST_SW_RD;
          default:   state_d = ST_T_I;
        endcase
      end
      ST_V_RL:    state_d = st_i.lo_lt_hi ? ST_V_RH : ST_PASS;
      ST_V_RH:    state_d = ST_V_WL;
      ST_V_WL:    state_d = ST_V_WH;
      ST_V_WH:    state_d = ST_V_RL;
      ST_SW_RD:   state_d = ST_SW_WR;
      ST_SW_WR:   state_d = ST_PASS;
      ST_T_I:     state_d = ST_T_RD;
      ST_T_RD:    state_d = st_i.i_end ? ST_E_RD : ST_T_RD1;
      ST_T_RD1:   state_d = ST_T_RD2;
      ST_T_RD2:   state_d = ST_T_D;
      ST_T_D:     state_d = ST_T_A;
      ST_T_A:     state_d = ST_T_RD;
      ST_E_RD:    state_d = ST_E_LD;
      ST_E_LD:    state_d = ST_E_WAIT;
      ST_E_WAIT: begin
        if (!out_stall_i) begin
          state_d = st_i.e_last ? ST_IDLE : ST_E_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE:    cmd_o.op = OP_IDLE;
      ST_W_D0:    cmd_o.op = OP_W_D0;
      ST_W_D1:    cmd_o.op = OP_W_D1;
      ST_W_C:     cmd_o.op = OP_W_C;
      ST_W_T:     cmd_o.op = OP_W_T;
      ST_MAP_CLR: cmd_o.op = OP_MAP_CLR;
      ST_MAP_RD:  cmd_o.op = OP_MAP_RD;
      ST_MAP_SET: cmd_o.op = OP_MAP_SET;
      ST_PASS:    cmd_o.op = OP_PASS;
      ST_O_I:     cmd_o.op = OP_O_I;
      ST_O_I2:    cmd_o.op = OP_O_I2;
      ST_O_I3:    cmd_o.op = OP_O_I3;
      ST_O_J0:    cmd_o.op = OP_O_J0;
      ST_O_J1:    cmd_o.op = OP_O_J1;
      ST_O_J2:    cmd_o.op = OP_O_J2;
      ST_O_J3:    cmd_o.op = OP_O_J3;
      ST_O_J4:    cmd_o.op = OP_O_J4;
      ST_O_J5:    cmd_o.op = OP_O_J5;
      ST_O_J6:    cmd_o.op = OP_O_J6;
      ST_S_I:     cmd_o.op = OP_S_I;
      ST_S_I1:    cmd_o.op = OP_S_I1;
      ST_S_I2:    cmd_o.op = OP_S_I2;
      ST_S_I3:    cmd_o.op = OP_S_I3;
      ST_S_I4:    cmd_o.op = OP_S_I4;
      ST_S_I5:    cmd_o.op = OP_S_I5;
      ST_S_I6:    cmd_o.op = OP_S_I6;
      ST_S_J0:    cmd_o.op = OP_S_J0;
      ST_S_J1:    cmd_o.op = OP_S_J1;
      ST_S_J2:    cmd_o.op = OP_S_J2;
      ST_S_J3:    cmd_o.op = OP_S_J3;
      ST_AP:      cmd_o.op = OP_AP;
      ST_V_RL:    cmd_o.op = OP_V_RL;
      ST_V_RH:    cmd_o.op = OP_V_RH;
      ST_V_WL:    cmd_o.op = OP_V_WL;
      ST_V_WH:    cmd_o.op = OP_V_WH;
      ST_SW_RD:   cmd_o.op = OP_SW_RD;
      ST_SW_WR:   cmd_o.op = OP_SW_WR;
      ST_T_I:     cmd_o.op = OP_T_I;
      ST_T_RD:    cmd_o.op = OP_T_RD;
      ST_T_RD1:   cmd_o.op = OP_T_RD1;
      ST_T_RD2:   cmd_o.op = OP_T_RD2;
      ST_T_D:     cmd_o.op = OP_T_D;
      ST_T_A:     cmd_o.op = OP_T_A;
      ST_E_RD:    cmd_o.op = OP_E_RD;
      ST_E_LD:    cmd_o.op = OP_E_LD;
      ST_E_WAIT:  cmd_o.op = out_stall_i ? OP_NONE : OP_E_ADV;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_E_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tols_dp.sv
`default_nettype none

module tols_dp
  import tols_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                st_o,
  input  wire in_word_t          in_word_i,
  output out_word_t              out_word_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i
);

  // configuration
  logic [7:0] cfg_nodes_q;
  logic [6:0] cfg_tour_q;
  logic       cfg_intra_q;
  logic [TCNT_W-1:0] n;
  logic [NCNT_W-1:0] nodes;

  in_word_t item_q;

  // search registers
  logic [TCNT_W-1:0]    i_q;
  logic [JW-1:0]        j_q;
  logic [TNODE_W-1:0]   na_q, nan_q, nb_q, nbn_q;
  logic signed [DW-1:0] acc_q, oc_q, best_q;
  kind_e                kind_q;
  logic [TIDX_W-1:0]    ba_q;
  logic [JW-1:0]        bb_q;
  logic [ACC_W-1:0]     tot_q;
  logic [MAX_NODES-1:0] map_q;
  logic [MAX_NODES-1:0] sw_map;
  logic                 dz_q, cz_q;
  out_word_t            out_q;

  // memory ports
  logic                  t_we;
  logic [TIDX_W-1:0]     t_wa, t_ra;
  logic [TNODE_W-1:0]    t_wd, t_rd;
  logic                  d_we;
  logic [2*NODE_W-1:0]   d_wa, d_ra;
  logic [DIST_BITS-1:0]  d_rd;
  logic                  d_ok;
  logic                  c_we;
  logic [NODE_W-1:0]     c_wa, c_ra;
  logic [DIST_BITS-1:0]  c_rd;
  logic                  c_ok;
  logic [DIST_BITS-1:0]  val;

  logic [DIST_BITS-1:0]  dv, cv;
  logic signed [DW-1:0]  dve, cve, two_d, swap_d;
  logic [TCNT_W-1:0]     i_nx, i_pv, jt, j_nx;
  logic [COST_W-1:0]     tot_sat;

  function automatic logic in_rng(logic [TNODE_W-1:0] x);
    return int'(x) < MAX_NODES;
  endfunction

  always_comb begin
    n = TCNT_W'(MAX_TOUR);
    if (int'(cfg_tour_q) < 3) begin
      n = TCNT_W'(3);
    end else if (int'(cfg_tour_q) <= MAX_TOUR) begin
      n = TCNT_W'(cfg_tour_q);
    end
    nodes = NCNT_W'(MAX_NODES);
    if (int'(cfg_nodes_q) < 2) begin
      nodes = NCNT_W'(2);
    end else if (int'(cfg_nodes_q) <= MAX_NODES) begin
      nodes = NCNT_W'(cfg_nodes_q);
    end
  end

  assign i_nx = (i_q + TCNT_W'(1) == n) ? '0 : i_q + TCNT_W'(1);
  assign i_pv = (i_q == '0) ? n - TCNT_W'(1) : i_q - TCNT_W'(1);
  assign jt   = TCNT_W'(j_q);
  assign j_nx = (jt + TCNT_W'(1) == n) ? '0 : jt + TCNT_W'(1);

  assign val = DIST_BITS'(item_q.value);
  assign dv  = dz_q ? '0 : d_rd;
  assign cv  = cz_q ? '0 : c_rd;
  assign dve = DW'(dv);
  assign cve = DW'(cv);
  assign two_d  = acc_q - dve;
  assign swap_d = acc_q + dve - oc_q;
  assign tot_sat = (tot_q > ACC_W'(COST_SAT)) ? COST_SAT : COST_W'(tot_q);

  // membership after a swap: old node out, new node in
  always_comb begin
    sw_map = map_q;
    if (in_rng(t_rd)) sw_map[NODE_W'(t_rd)] = 1'b0;
    sw_map[NODE_W'(bb_q)] = 1'b1;
  end

  // memory addressing
  always_comb begin
    t_we = 1'b0;
    t_wa = TIDX_W'(item_q.tour_pos);
    t_wd = item_q.row_node;
    t_ra = TIDX_W'(i_q);
    d_we = 1'b0;
    d_wa = {NODE_W'(item_q.row_node), NODE_W'(item_q.col_node)};
    d_ra = {NODE_W'(na_q), NODE_W'(nb_q)};
    d_ok = in_rng(na_q) && in_rng(nb_q);
    c_we = 1'b0;
    c_wa = NODE_W'(item_q.row_node);
    c_ra = NODE_W'(na_q);
    c_ok = in_rng(na_q);
    case (cmd_i.op)
      OP_W_D0: d_we = in_rng(item_q.row_node) && in_rng(item_q.col_node);
      OP_W_D1: begin
        d_we = in_rng(item_q.row_node) && in_rng(item_q.col_node);
        d_wa = {NODE_W'(item_q.col_node), NODE_W'(item_q.row_node)};
      end
      OP_W_C:  c_we = in_rng(item_q.row_node);
      OP_W_T:  t_we = int'(item_q.tour_pos) < MAX_TOUR;
      OP_O_I2, OP_S_I1, OP_T_RD1: t_ra = TIDX_W'(i_nx);
      OP_S_I2: t_ra = TIDX_W'(i_pv);
      OP_O_J0, OP_V_RH: t_ra = TIDX_W'(j_q);
      OP_O_J1: t_ra = TIDX_W'(j_nx);
      OP_SW_RD: t_ra = ba_q;
      OP_O_J3: begin
        d_ra = {NODE_W'(nan_q), NODE_W'(nbn_q)};
        d_ok = in_rng(nan_q) && in_rng(nbn_q);
      end
      OP_O_J4, OP_S_I4, OP_T_D: begin
        d_ra = {NODE_W'(na_q), NODE_W'(nan_q)};
        d_ok = in_rng(na_q) && in_rng(nan_q);
      end
      OP_O_J5: begin
        d_ra = {NODE_W'(nb_q), NODE_W'(nbn_q)};
        d_ok = in_rng(nb_q) && in_rng(nbn_q);
      end
      OP_S_J0: begin
        c_ra = NODE_W'(j_q);
        c_ok = 1'b1;
      end
      OP_S_J1: begin
        d_ra = {NODE_W'(j_q), NODE_W'(nan_q)};
        d_ok = in_rng(nan_q);
      end
      OP_S_J2: begin
        d_ra = {NODE_W'(j_q), NODE_W'(nb_q)};
        d_ok = in_rng(nb_q);
      end
      OP_V_WL: begin
        t_we = 1'b1;
        t_wa = TIDX_W'(i_q);
        t_wd = t_rd;
      end
      OP_V_WH: begin
        t_we = 1'b1;
        t_wa = TIDX_W'(j_q);
        t_wd = na_q;
      end
      OP_SW_WR: begin
        t_we = 1'b1;
        t_wa = ba_q;
        t_wd = TNODE_W'(bb_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nodes_q <= 8'd128;
      cfg_tour_q  <= 7'd64;
      cfg_intra_q <= 1'b1;
      map_q       <= '0;
      kind_q      <= KIND_NONE;
      best_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_COUNT:   cfg_nodes_q <= cfg_data_i;
          CFG_TOUR_LENGTH:  cfg_tour_q  <= cfg_data_i[6:0];
          CFG_INTRA_ENABLE: cfg_intra_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_MAP_CLR: map_q <= '0;
        OP_MAP_SET: begin
          if (in_rng(t_rd)) map_q[NODE_W'(t_rd)] <= 1'b1;
        end
        OP_PASS: begin
          best_q <= '0;
          kind_q <= KIND_NONE;
        end
        OP_O_J6: begin
          if (two_d < best_q) begin
            best_q <= two_d;
            kind_q <= KIND_TWO;
          end
        end
        OP_S_J3: begin
          if (swap_d < best_q) begin
            best_q <= swap_d;
            kind_q <= KIND_SWAP;
          end
        end
        OP_SW_WR: map_q <= sw_map;
        default: ;
      endcase
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    dz_q <= !d_ok;
    cz_q <= !c_ok;
    case (cmd_i.op)
      OP_IDLE:    item_q <= in_word_i;
      OP_MAP_CLR: i_q <= '0;
      OP_MAP_SET: i_q <= i_q + TCNT_W'(1);
      OP_PASS: begin
        i_q  <= '0;
        ba_q <= '0;
        bb_q <= '0;
      end
      OP_O_I: begin
        j_q <= JW'(i_q) + JW'(2);
        if (st_o.i_two_end) i_q <= '0;
      end
      OP_O_I2, OP_S_I1, OP_T_RD1: na_q <= t_rd;
      OP_O_I3, OP_S_I2, OP_T_RD2: nan_q <= t_rd;
      OP_O_J1, OP_S_I3: nb_q <= t_rd;
      OP_O_J2: nbn_q <= t_rd;
      OP_O_J3: acc_q <= dve;
      OP_O_J4: acc_q <= acc_q + dve;
      OP_O_J5: acc_q <= acc_q - dve;
      OP_O_J6: begin
        if (two_d < best_q) begin
          ba_q <= TIDX_W'(i_q);
          bb_q <= j_q;
        end
        if (st_o.j_last_t) begin
          i_q <= i_q + TCNT_W'(1);
        end else begin
          j_q <= j_q + JW'(1);
        end
      end
      OP_S_I4: oc_q <= cve;
      OP_S_I5: oc_q <= oc_q + dve;
      OP_S_I6: begin
        oc_q <= oc_q + dve;
        j_q  <= '0;
      end
      OP_S_J0: begin
        if (st_o.j_end_n) begin
          i_q <= i_q + TCNT_W'(1);
        end else if (st_o.j_in_map) begin
          j_q <= j_q + JW'(1);
        end
      end
      OP_S_J1: acc_q <= cve;
      OP_S_J2: acc_q <= acc_q + dve;
      OP_S_J3: begin
        if (swap_d < best_q) begin
          ba_q <= TIDX_W'(i_q);
          bb_q <= j_q;
        end
        j_q <= j_q + JW'(1);
      end
      OP_AP: begin
        i_q <= TCNT_W'(ba_q) + TCNT_W'(1);
        j_q <= bb_q;
      end
      OP_V_RH: na_q <= t_rd;
      OP_V_WH: begin
        i_q <= i_q + TCNT_W'(1);
        j_q <= j_q - JW'(1);
      end
      OP_T_I: begin
        i_q   <= '0;
        tot_q <= '0;
      end
      OP_T_RD: begin
        if (st_o.i_end) i_q <= '0;
      end
      OP_T_D: tot_q <= tot_q + ACC_W'(cv);
      OP_T_A: begin
        tot_q <= tot_q + ACC_W'(dv);
        i_q   <= i_q + TCNT_W'(1);
      end
      OP_E_LD: begin
        out_q.tour_node  <= t_rd;
        out_q.out_pos    <= 6'(i_q);
        out_q.total_cost <= tot_sat;
        out_q.last       <= st_o.e_last;
      end
      OP_E_ADV: i_q <= i_q + TCNT_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    st_o.func      = func_e'(in_word_i.func);
    st_o.intra     = cfg_intra_q;
    st_o.i_end     = (i_q >= n);
    st_o.i_two_end = ((TCNT_W+1)'(i_q) + (TCNT_W+1)'(2)) >= (TCNT_W+1)'(n);
    st_o.j_last_t  = ((JW+1)'(j_q) + (JW+1)'(1)) >= (JW+1)'(n);
    st_o.j_end_n   = (JW+1)'(j_q) >= (JW+1)'(nodes);
    st_o.j_in_map  = map_q[NODE_W'(j_q)];
    st_o.lo_lt_hi  = JW'(i_q) < j_q;
    st_o.e_last    = ((TCNT_W+1)'(i_q) + (TCNT_W+1)'(1)) == (TCNT_W+1)'(n);
    st_o.kind      = kind_q;
  end

  assign out_word_o = out_q;

  tols_ram #(.Width(TNODE_W), .Depth(MAX_TOUR)) u_tour_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_wa),
    .wdata_i (t_wd),
    .raddr_i (t_ra),
    .rdata_o (t_rd)
  );

  tols_ram #(.Width(DIST_BITS), .Depth(MAX_NODES * MAX_NODES)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_wa),
    .wdata_i (val),
    .raddr_i (d_ra),
    .rdata_o (d_rd)
  );

  tols_ram #(.Width(DIST_BITS), .Depth(MAX_NODES)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_wa),
    .wdata_i (val),
    .raddr_i (c_ra),
    .rdata_o (c_rd)
  );

`ifndef ASSERT_OFF
  a_best_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q != KIND_NONE |-> best_q < 0)
    else $error("move recorded without negative delta");

  a_swap_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SW_WR |=> map_q[$past(NODE_W'(bb_q))])
    else $error("swapped-in node not marked in map");

  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_O_J0 |-> (JW+1)'(j_q) < (JW+1)'(n))
    else $error("2-opt partner position past tour end");
`endif

endmodule

`default_nettype wire
